// ===== rtl/csma_pkg.sv =====
// Shared package for the CSMA/CA MAC controller: event, state and action codes,
// register indexes, and the command/status structs between controller and datapath.
// No dependencies.
package csma_pkg;

  localparam int SUB_SLOTS_DEF = 90;

  localparam int KIND_W = 3;
  localparam int MED_W = 2;
  localparam int ADDR_W = 48;
  localparam int DRAW_W = 32;
  localparam int ACT_W = 4;
  localparam int MST_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TIME_W = 16;
  localparam int CW_W = 10;
  localparam int RETRY_W = 4;
  localparam int CW_FULL_W = 26;
  localparam int CW_TOP = 1021;

  localparam logic [KIND_W-1:0] K_TICK = 3'd0;
  localparam logic [KIND_W-1:0] K_FRAME = 3'd1;
  localparam logic [KIND_W-1:0] K_MEDIUM = 3'd2;
  localparam logic [KIND_W-1:0] K_RX_END = 3'd3;
  localparam logic [KIND_W-1:0] K_TX_DONE = 3'd4;

  localparam logic [MED_W-1:0] MED_IDLE = 2'd0;
  localparam logic [MED_W-1:0] MED_RECV = 2'd2;

  localparam logic [MST_W-1:0] M_IDLE = 3'd0;
  localparam logic [MST_W-1:0] M_DEFER = 3'd1;
  localparam logic [MST_W-1:0] M_DIFS = 3'd2;
  localparam logic [MST_W-1:0] M_BACKOFF = 3'd3;
  localparam logic [MST_W-1:0] M_TRANSMIT = 3'd4;
  localparam logic [MST_W-1:0] M_ACKWAIT = 3'd5;
  localparam logic [MST_W-1:0] M_RECEIVE = 3'd6;
  localparam logic [MST_W-1:0] M_SIFS = 3'd7;

  localparam logic [ACT_W-1:0] A_NONE = 4'd0;
  localparam logic [ACT_W-1:0] A_SEND_DATA = 4'd1;
  localparam logic [ACT_W-1:0] A_SEND_ACK = 4'd2;
  localparam logic [ACT_W-1:0] A_DELIVER = 4'd3;
  localparam logic [ACT_W-1:0] A_DROP_FCS = 4'd4;
  localparam logic [ACT_W-1:0] A_DROP_ADDR = 4'd5;
  localparam logic [ACT_W-1:0] A_TX_OK = 4'd6;
  localparam logic [ACT_W-1:0] A_TX_BCAST = 4'd7;
  localparam logic [ACT_W-1:0] A_GIVE_UP = 4'd8;
  localparam logic [ACT_W-1:0] A_RETRY = 4'd9;

  localparam logic [CFG_IDX_W-1:0] R_USE_ACK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] R_DIFS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] R_SIFS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] R_ACK_TO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] R_CW_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] R_CW_MAX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] R_CW_MC = 3'd6;
  localparam logic [CFG_IDX_W-1:0] R_RETRY = 3'd7;

  typedef struct packed {
    logic capture;  // latch the input word
    logic eval;     // evaluate event, latch contention window
    logic load;     // load divider
    logic step;     // one divider step
    logic commit;   // update MAC state, load output register
  } cmd_t;

  typedef struct packed {
    logic gen_needed;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/csma_ctrl.sv =====
// Sequencer for the CSMA/CA MAC controller: accepts a word, evaluates it,
// runs the backoff divider when needed, and commits. Uses csma_pkg.
module csma_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  csma_pkg::status_t  status,
  output csma_pkg::cmd_t     cmd
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_EVAL = 3'd1;
  localparam logic [2:0] C_LOAD = 3'd2;
  localparam logic [2:0] C_DIV = 3'd3;
  localparam logic [2:0] C_DONE = 3'd4;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = (state == C_IDLE);
    unique case (state)
      C_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = C_EVAL;
        end
      end
      C_EVAL: begin
        cmd.eval = 1'b1;
        state_next = status.gen_needed ? C_LOAD : C_DONE;
      end
      C_LOAD: begin
        cmd.load = 1'b1;
        state_next = C_DIV;
      end
      C_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) state_next = C_DONE;
      end
      C_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= C_IDLE;
    else state <= state_next;
  end

endmodule

// ===== rtl/csma_dp.sv =====
// Datapath of the CSMA/CA MAC controller: config registers, MAC state, event
// evaluation, restoring divider for the backoff draw, output register. Uses csma_pkg.
module csma_dp #(
  parameter int SUB_SLOTS = csma_pkg::SUB_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  csma_pkg::cmd_t                   cmd,
  output csma_pkg::status_t                status,
  input  logic                             cfg_valid,
  input  logic [csma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csma_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [csma_pkg::KIND_W-1:0]      kind,
  input  logic [csma_pkg::MED_W-1:0]       medium_req,
  input  logic                             fcs_ok,
  input  logic                             for_us,
  input  logic                             frame_is_ack,
  input  logic                             dest_broadcast,
  input  logic                             dest_multicast,
  input  logic [csma_pkg::ADDR_W-1:0]      source_address,
  input  logic [csma_pkg::DRAW_W-1:0]      random_draw,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [csma_pkg::ACT_W-1:0]       action,
  output logic [csma_pkg::MST_W-1:0]       mac_state,
  output logic [csma_pkg::ADDR_W-1:0]      ack_destination,
  output logic                             want_frame
);

  localparam int DW = $clog2(csma_pkg::CW_TOP * SUB_SLOTS + 2);
  localparam int TW = (DW > csma_pkg::TIME_W) ? DW : csma_pkg::TIME_W;
  localparam int EW = (SUB_SLOTS > 1) ? $clog2(SUB_SLOTS) : 1;
  localparam int CNT_W = $clog2(csma_pkg::DRAW_W);

  // config
  logic                          use_ack;
  logic [csma_pkg::TIME_W-1:0]   difs_ticks, sifs_ticks, ack_timeout_ticks;
  logic [csma_pkg::CW_W-1:0]     cw_min, cw_max, cw_multicast;
  logic [csma_pkg::RETRY_W-1:0]  retry_limit;

  // captured word
  logic [csma_pkg::KIND_W-1:0]   i_kind;
  logic [csma_pkg::MED_W-1:0]    i_med;
  logic                          i_fcs, i_forus, i_isack, i_bc, i_mc;
  logic [csma_pkg::ADDR_W-1:0]   i_src;
  logic [csma_pkg::DRAW_W-1:0]   quot;

  // MAC state
  logic [csma_pkg::MST_W-1:0]    mst;
  logic [DW-1:0]                 bo_left;
  logic                          bo_valid;
  logic [DW-1:0]                 el_slots;
  logic [EW-1:0]                 el_sub;
  logic [TW-1:0]                 timer;
  logic [csma_pkg::RETRY_W-1:0]  retry;
  logic [2:0]                    flags;  // held, broadcast, multicast
  logic [csma_pkg::ADDR_W-1:0]   ack_addr;

  // divider
  logic [csma_pkg::CW_W-1:0]     cw_reg;
  logic [DW-1:0]                 divisor, rem;
  logic [CNT_W-1:0]              cnt;

  // evaluation
  logic [csma_pkg::MST_W-1:0]    st;
  logic [DW-1:0]                 bl, es;
  logic [EW-1:0]                 et;
  logic                          bv, sf, eb, gen, gmc, free_m, recv_m;
  logic [TW-1:0]                 tl;
  logic [csma_pkg::RETRY_W-1:0]  rc, grc;
  logic [2:0]                    fl;
  logic [csma_pkg::ADDR_W-1:0]   aa;
  logic [csma_pkg::ACT_W-1:0]    act;
  logic [2*DW-1:0]               whole;
  logic [csma_pkg::CW_FULL_W-1:0] cw_full;
  logic [csma_pkg::CW_W-1:0]     cw;
  logic [DW:0]                   trial;

  always_comb begin
    st = mst; bl = bo_left; bv = bo_valid; es = el_slots; et = el_sub;
    tl = timer; rc = retry; fl = flags; aa = ack_addr; act = csma_pkg::A_NONE;
    sf = 1'b0; eb = 1'b0; gen = 1'b0; gmc = 1'b0; grc = retry;
    whole = '0;
    free_m = (i_med == csma_pkg::MED_IDLE);
    recv_m = (i_med == csma_pkg::MED_RECV);
    if (i_kind == csma_pkg::K_FRAME) begin
      if (!fl[0]) begin
        fl = {i_mc, i_bc, 1'b1};
        bv = 1'b0; bl = '0; rc = '0;
        if (st == csma_pkg::M_IDLE) sf = 1'b1;
      end
    end else begin
      case (st)
        csma_pkg::M_DEFER: begin
          if (i_kind == csma_pkg::K_MEDIUM) begin
            if (free_m) sf = 1'b1;
            else if (recv_m) st = csma_pkg::M_RECEIVE;
          end
        end
        csma_pkg::M_DIFS: begin
          if (i_kind == csma_pkg::K_TICK) begin
            if (tl != '0) tl = tl - TW'(1);
            if (tl == '0) eb = 1'b1;
          end else if (i_kind == csma_pkg::K_MEDIUM) begin
            if (recv_m) st = csma_pkg::M_RECEIVE;
            else if (!free_m) st = csma_pkg::M_DEFER;
          end
        end
        csma_pkg::M_BACKOFF: begin
          if (i_kind == csma_pkg::K_TICK) begin
            if (et == EW'(SUB_SLOTS - 1)) begin
              et = '0;
              es = es + DW'(1);
            end else begin
              et = et + EW'(1);
            end
            if (tl != '0) tl = tl - TW'(1);
            if (tl == '0) begin
              bv = 1'b0; bl = '0;
              st = csma_pkg::M_TRANSMIT;
              act = csma_pkg::A_SEND_DATA;
            end
          end else if (i_kind == csma_pkg::K_MEDIUM && !free_m) begin
            // frozen backoff keeps the partial slot
            whole = {{DW{1'b0}}, es} * (2*DW)'(SUB_SLOTS);
            if (whole > {{DW{1'b0}}, bl}) whole = {{DW{1'b0}}, bl};
            bl = bl - whole[DW-1:0];
            es = '0; et = '0;
            st = recv_m ? csma_pkg::M_RECEIVE : csma_pkg::M_DEFER;
          end
        end
        csma_pkg::M_TRANSMIT: begin
          if (i_kind == csma_pkg::K_TX_DONE) begin
            if (fl[1]) begin
              fl = '0; bv = 1'b0; bl = '0; rc = '0;
              st = csma_pkg::M_IDLE; act = csma_pkg::A_TX_BCAST;
            end else if (!use_ack) begin
              fl = '0; bv = 1'b0; bl = '0; rc = '0;
              st = csma_pkg::M_IDLE; act = csma_pkg::A_TX_OK;
            end else begin
              tl = TW'(ack_timeout_ticks);
              st = csma_pkg::M_ACKWAIT;
            end
          end
        end
        csma_pkg::M_ACKWAIT: begin
          if (i_kind == csma_pkg::K_RX_END) begin
            if (i_fcs && i_forus && i_isack) begin
              fl = '0; bv = 1'b0; bl = '0; rc = '0;
              st = csma_pkg::M_IDLE; act = csma_pkg::A_TX_OK;
            end
          end else if (i_kind == csma_pkg::K_TICK) begin
            if (tl != '0) tl = tl - TW'(1);
            if (tl == '0) begin
              st = csma_pkg::M_IDLE;
              if (rc >= retry_limit) begin
                fl = '0; bv = 1'b0; bl = '0; rc = '0;
                act = csma_pkg::A_GIVE_UP;
              end else begin
                rc = rc + csma_pkg::RETRY_W'(1);
                gen = 1'b1; gmc = fl[1] | fl[2]; grc = rc;
                bl = rem; bv = 1'b1;
                act = csma_pkg::A_RETRY;
              end
            end
          end
        end
        csma_pkg::M_RECEIVE: begin
          if (i_kind == csma_pkg::K_RX_END) begin
            st = csma_pkg::M_IDLE;
            if (!i_fcs) act = csma_pkg::A_DROP_FCS;
            else if (i_isack) act = csma_pkg::A_NONE;
            else if (i_bc) act = csma_pkg::A_DELIVER;
            else if (i_forus) begin
              act = csma_pkg::A_DELIVER;
              if (use_ack) begin
                aa = i_src;
                tl = TW'(sifs_ticks);
                st = csma_pkg::M_SIFS;
              end
            end else act = csma_pkg::A_DROP_ADDR;
          end
        end
        csma_pkg::M_SIFS: begin
          if (i_kind == csma_pkg::K_TICK) begin
            if (tl != '0) tl = tl - TW'(1);
            if (tl == '0) begin
              st = csma_pkg::M_IDLE;
              act = csma_pkg::A_SEND_ACK;
            end
          end
        end
        default: ;
      endcase
    end
    // idle resolution
    if (!sf && st == csma_pkg::M_IDLE) begin
      if (recv_m) st = csma_pkg::M_RECEIVE;
      else if (fl[0]) sf = 1'b1;
    end
    if (sf) begin
      if (!free_m) st = csma_pkg::M_DEFER;
      else if (use_ack) begin
        tl = TW'(difs_ticks);
        st = csma_pkg::M_DIFS;
      end else eb = 1'b1;
    end
    if (eb) begin
      if (!bv) begin
        gen = 1'b1; gmc = fl[1] | fl[2]; grc = rc;
        bl = rem; bv = 1'b1;
      end
      tl = TW'(bl);
      es = '0; et = '0;
      st = csma_pkg::M_BACKOFF;
    end
  end

  // contention window for the generated backoff
  always_comb begin
    cw_full = ((csma_pkg::CW_FULL_W)'(cw_min) + csma_pkg::CW_FULL_W'(1)) << grc;
    cw_full = cw_full - csma_pkg::CW_FULL_W'(1);
    if (gmc) cw = cw_multicast;
    else if (cw_full > csma_pkg::CW_FULL_W'(cw_max)) cw = cw_max;
    else cw = cw_full[csma_pkg::CW_W-1:0];
    if (cw < csma_pkg::CW_W'(2)) cw = csma_pkg::CW_W'(2);
  end

  assign trial = {rem, quot[csma_pkg::DRAW_W-1]};

  assign status.gen_needed = gen;
  assign status.div_last = (cnt == CNT_W'(csma_pkg::DRAW_W - 1));
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_ack <= 1'b1;
      difs_ticks <= '0; sifs_ticks <= '0; ack_timeout_ticks <= '0;
      cw_min <= csma_pkg::CW_W'(31); cw_max <= csma_pkg::CW_W'(1023);
      cw_multicast <= csma_pkg::CW_W'(31); retry_limit <= csma_pkg::RETRY_W'(7);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        csma_pkg::R_USE_ACK: use_ack <= cfg_data[0];
        csma_pkg::R_DIFS:    difs_ticks <= cfg_data;
        csma_pkg::R_SIFS:    sifs_ticks <= cfg_data;
        csma_pkg::R_ACK_TO:  ack_timeout_ticks <= cfg_data;
        csma_pkg::R_CW_MIN:  cw_min <= cfg_data[csma_pkg::CW_W-1:0];
        csma_pkg::R_CW_MAX:  cw_max <= cfg_data[csma_pkg::CW_W-1:0];
        csma_pkg::R_CW_MC:   cw_multicast <= cfg_data[csma_pkg::CW_W-1:0];
        csma_pkg::R_RETRY:   retry_limit <= cfg_data[csma_pkg::RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      i_kind <= kind; i_med <= medium_req; i_fcs <= fcs_ok; i_forus <= for_us;
      i_isack <= frame_is_ack; i_bc <= dest_broadcast; i_mc <= dest_multicast;
      i_src <= source_address;
      quot <= random_draw;
      rem <= '0;
    end else if (cmd.step) begin
      quot <= {quot[csma_pkg::DRAW_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) rem <= DW'(trial - {1'b0, divisor});
      else rem <= trial[DW-1:0];
    end
    if (cmd.eval) cw_reg <= cw;
    if (cmd.load) divisor <= DW'(cw_reg - csma_pkg::CW_W'(2)) * DW'(SUB_SLOTS) + DW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else if (cmd.load) cnt <= '0;
    else if (cmd.step) cnt <= cnt + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mst <= csma_pkg::M_IDLE; bo_left <= '0; bo_valid <= 1'b0;
      el_slots <= '0; el_sub <= '0; timer <= '0; retry <= '0;
      flags <= '0; ack_addr <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.commit) begin
        mst <= st; bo_left <= bl; bo_valid <= bv; el_slots <= es; el_sub <= et;
        timer <= tl; retry <= rc; flags <= fl; ack_addr <= aa;
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      action <= act;
      mac_state <= st;
      ack_destination <= (act == csma_pkg::A_SEND_ACK) ? aa : '0;
      want_frame <= (st == csma_pkg::M_IDLE) && !fl[0];
    end
  end

endmodule

// ===== rtl/csma_ca_mac_controller.sv =====
// Top level of the CSMA/CA MAC controller with binary exponential backoff.
// Instantiates csma_ctrl (sequencer) and csma_dp (datapath); uses csma_pkg.
//
// Usage:
//   Each word on the input channel (in_valid/in_ready) is one MAC event:
//   a tick, a new frame, a medium change, a received frame end or transmit
//   done. Each event gives exactly one word on the output channel
//   (out_valid/out_ready): action code, state after the event, ACK address
//   and want_frame.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; writes
//   are always taken and must only come while no event is in flight.
// Sequencing:
//   An event without backoff generation goes from accept through evaluate to
//   commit. An event that draws a backoff loads and runs a restoring divider, one
//   quotient bit per cycle over the 32-bit random draw, before its commit.
//   One event is in work at a time; in_ready is high only in the idle step,
//   so a new event is taken only once the last one has been committed.
//   The output register holds a finished word while out_ready is low; the next
//   event may be accepted meanwhile, and it waits in its commit step.
// Reset: synchronous rst sets the MAC idle with no frame held and loads the
//   register defaults.
module csma_ca_mac_controller #(
  parameter int SUB_SLOTS = csma_pkg::SUB_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [csma_pkg::KIND_W-1:0]      kind,
  input  logic [csma_pkg::MED_W-1:0]       medium_req,
  input  logic                             fcs_ok,
  input  logic                             for_us,
  input  logic                             frame_is_ack,
  input  logic                             dest_broadcast,
  input  logic                             dest_multicast,
  input  logic [csma_pkg::ADDR_W-1:0]      source_address,
  input  logic [csma_pkg::DRAW_W-1:0]      random_draw,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [csma_pkg::ACT_W-1:0]       action,
  output logic [csma_pkg::MST_W-1:0]       mac_state,
  output logic [csma_pkg::ADDR_W-1:0]      ack_destination,
  output logic                             want_frame,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [csma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csma_pkg::CFG_DATA_W-1:0]  cfg_data
);

  csma_pkg::cmd_t    cmd;
  csma_pkg::status_t status;

  assign cfg_ready = 1'b1;

  csma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  csma_dp #(.SUB_SLOTS(SUB_SLOTS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .medium_req      (medium_req),
    .fcs_ok          (fcs_ok),
    .for_us          (for_us),
    .frame_is_ack    (frame_is_ack),
    .dest_broadcast  (dest_broadcast),
    .dest_multicast  (dest_multicast),
    .source_address  (source_address),
    .random_draw     (random_draw),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .action          (action),
    .mac_state       (mac_state),
    .ack_destination (ack_destination),
    .want_frame      (want_frame)
  );

endmodule

// ===== test/csma_ca_mac_checker.sv =====
`timescale 1ns / 100ps
// Checker for the CSMA/CA MAC controller: watches the event, result and register
// channels, predicts each result word and compares it. Uses csma_pkg.
module csma_ca_mac_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [csma_pkg::KIND_W-1:0]     kind,
  input  logic [csma_pkg::MED_W-1:0]      medium_req,
  input  logic                            fcs_ok,
  input  logic                            for_us,
  input  logic                            frame_is_ack,
  input  logic                            dest_broadcast,
  input  logic                            dest_multicast,
  input  logic [csma_pkg::ADDR_W-1:0]     source_address,
  input  logic [csma_pkg::DRAW_W-1:0]     random_draw,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [csma_pkg::ACT_W-1:0]      action,
  input  logic [csma_pkg::MST_W-1:0]      mac_state,
  input  logic [csma_pkg::ADDR_W-1:0]     ack_destination,
  input  logic                            want_frame,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [csma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csma_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);

  localparam int SLOT = csma_pkg::SUB_SLOTS_DEF;

  typedef struct packed {
    logic [csma_pkg::ACT_W-1:0]  act;
    logic [csma_pkg::MST_W-1:0]  st;
    logic [csma_pkg::ADDR_W-1:0] dst;
    logic                        want;
  } mac_word_t;

  mac_word_t expected_words[$];

  // register copies
  logic        r_use_ack;
  logic [15:0] r_difs, r_sifs, r_ack_to;
  logic [9:0]  r_cw_min, r_cw_max, r_cw_mc;
  logic [3:0]  r_retry_lim;

  // MAC state copies
  logic [csma_pkg::MST_W-1:0]  m_state;
  logic [31:0]                 bo_left, bo_elapsed, timer;
  logic                        bo_valid;
  logic [3:0]                  retries;
  logic                        held, held_bc, held_mc;
  logic [csma_pkg::ADDR_W-1:0] ack_addr;

  assign pending = expected_words.size();

  task automatic draw_backoff(input logic [31:0] draw);
    logic [63:0] cw;
    if (held_bc || held_mc) cw = 64'(r_cw_mc);
    else begin
      cw = ((64'(r_cw_min) + 1) << retries) - 1;
      if (cw > 64'(r_cw_max)) cw = 64'(r_cw_max);
    end
    if (cw < 2) cw = 2;
    bo_left = 32'(64'(draw) % ((cw - 2) * SLOT + 1));
    bo_valid = 1'b1;
  endtask

  task automatic go_backoff(input logic [31:0] draw);
    if (!bo_valid) draw_backoff(draw);
    timer = bo_left;
    bo_elapsed = 0;
    m_state = csma_pkg::M_BACKOFF;
  endtask

  task automatic launch_frame(input logic [1:0] med, input logic [31:0] draw);
    if (med != csma_pkg::MED_IDLE) m_state = csma_pkg::M_DEFER;
    else if (r_use_ack) begin
      timer = 32'(r_difs);
      m_state = csma_pkg::M_DIFS;
    end else go_backoff(draw);
  endtask

  task automatic drop_frame();
    held = 0; held_bc = 0; held_mc = 0;
    bo_valid = 0; bo_left = 0; retries = 0;
  endtask

  function automatic logic timer_done();
    if (timer != 0) timer = timer - 1;
    return timer == 0;
  endfunction

  task automatic predict_event(output mac_word_t w);
    logic [3:0]                  act;
    logic [csma_pkg::ADDR_W-1:0] dst;
    logic                        busy, recv;
    logic [31:0]                 whole;
    act = csma_pkg::A_NONE;
    dst = '0;
    busy = medium_req != csma_pkg::MED_IDLE;
    recv = medium_req == csma_pkg::MED_RECV;
    if (kind == csma_pkg::K_FRAME) begin
      if (!held) begin
        held = 1; held_bc = dest_broadcast; held_mc = dest_multicast;
        bo_valid = 0; bo_left = 0; retries = 0;
        if (m_state == csma_pkg::M_IDLE) launch_frame(medium_req, random_draw);
      end
    end else begin
      case (m_state)
        csma_pkg::M_DEFER: if (kind == csma_pkg::K_MEDIUM) begin
          if (!busy) launch_frame(medium_req, random_draw);
          else if (recv) m_state = csma_pkg::M_RECEIVE;
        end
        csma_pkg::M_DIFS: begin
          if (kind == csma_pkg::K_TICK) begin
            if (timer_done()) go_backoff(random_draw);
          end else if (kind == csma_pkg::K_MEDIUM) begin
            if (recv) m_state = csma_pkg::M_RECEIVE;
            else if (busy) m_state = csma_pkg::M_DEFER;
          end
        end
        csma_pkg::M_BACKOFF: begin
          if (kind == csma_pkg::K_TICK) begin
            if (bo_elapsed != 32'hFFFF_FFFF) bo_elapsed++;
            if (timer_done()) begin
              bo_valid = 0; bo_left = 0;
              m_state = csma_pkg::M_TRANSMIT;
              act = csma_pkg::A_SEND_DATA;
            end
          end else if (kind == csma_pkg::K_MEDIUM && busy) begin
            // frozen backoff keeps partial slots
            whole = (bo_elapsed / SLOT) * SLOT;
            if (whole > bo_left) whole = bo_left;
            bo_left -= whole;
            bo_elapsed = 0;
            m_state = recv ? csma_pkg::M_RECEIVE : csma_pkg::M_DEFER;
          end
        end
        csma_pkg::M_TRANSMIT: if (kind == csma_pkg::K_TX_DONE) begin
          if (held_bc) begin
            drop_frame(); m_state = csma_pkg::M_IDLE; act = csma_pkg::A_TX_BCAST;
          end else if (!r_use_ack) begin
            drop_frame(); m_state = csma_pkg::M_IDLE; act = csma_pkg::A_TX_OK;
          end else begin
            timer = 32'(r_ack_to); m_state = csma_pkg::M_ACKWAIT;
          end
        end
        csma_pkg::M_ACKWAIT: begin
          if (kind == csma_pkg::K_RX_END) begin
            if (fcs_ok && for_us && frame_is_ack) begin
              drop_frame(); m_state = csma_pkg::M_IDLE; act = csma_pkg::A_TX_OK;
            end
          end else if (kind == csma_pkg::K_TICK && timer_done()) begin
            m_state = csma_pkg::M_IDLE;
            if (retries >= r_retry_lim) begin
              drop_frame(); act = csma_pkg::A_GIVE_UP;
            end else begin
              retries = 4'(retries + 1);
              draw_backoff(random_draw);
              act = csma_pkg::A_RETRY;
            end
          end
        end
        csma_pkg::M_RECEIVE: if (kind == csma_pkg::K_RX_END) begin
          m_state = csma_pkg::M_IDLE;
          if (!fcs_ok) act = csma_pkg::A_DROP_FCS;
          else if (frame_is_ack) act = csma_pkg::A_NONE;
          else if (dest_broadcast) act = csma_pkg::A_DELIVER;
          else if (for_us) begin
            act = csma_pkg::A_DELIVER;
            if (r_use_ack) begin
              ack_addr = source_address; timer = 32'(r_sifs);
              m_state = csma_pkg::M_SIFS;
            end
          end else act = csma_pkg::A_DROP_ADDR;
        end
        csma_pkg::M_SIFS: if (kind == csma_pkg::K_TICK && timer_done()) begin
          m_state = csma_pkg::M_IDLE; act = csma_pkg::A_SEND_ACK; dst = ack_addr;
        end
        default: ;
      endcase
    end
    if (m_state == csma_pkg::M_IDLE) begin
      if (recv) m_state = csma_pkg::M_RECEIVE;
      else if (held) launch_frame(medium_req, random_draw);
    end
    w.act = act;
    w.st = m_state;
    w.dst = dst;
    w.want = (m_state == csma_pkg::M_IDLE) && !held;
  endtask

  always @(posedge clk) begin
    mac_word_t w, e;
    if (rst) begin
      r_use_ack = 1; r_difs = 0; r_sifs = 0; r_ack_to = 0;
      r_cw_min = 31; r_cw_max = 1023; r_cw_mc = 31; r_retry_lim = 7;
      m_state = csma_pkg::M_IDLE; bo_left = 0; bo_valid = 0; bo_elapsed = 0;
      timer = 0; retries = 0; held = 0; held_bc = 0; held_mc = 0; ack_addr = 0;
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          csma_pkg::R_USE_ACK: r_use_ack = cfg_data[0];
          csma_pkg::R_DIFS:    r_difs = cfg_data;
          csma_pkg::R_SIFS:    r_sifs = cfg_data;
          csma_pkg::R_ACK_TO:  r_ack_to = cfg_data;
          csma_pkg::R_CW_MIN:  r_cw_min = cfg_data[9:0];
          csma_pkg::R_CW_MAX:  r_cw_max = cfg_data[9:0];
          csma_pkg::R_CW_MC:   r_cw_mc = cfg_data[9:0];
          csma_pkg::R_RETRY:   r_retry_lim = cfg_data[3:0];
          default: ;
        endcase
      end
      // check before predicting so the queue order holds
      if (out_valid && out_ready) begin
        w = '{action, mac_state, ack_destination, want_frame};
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", w);
        end else begin
          e = expected_words.pop_front();
          if (w !== e) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: act %0d/%0d state %0d/%0d dst %h/%h want %0d/%0d",
                       e.act, w.act, e.st, w.st, e.dst, w.dst, e.want, w.want);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_event(w);
        expected_words.push_back(w);
      end
    end
  end

endmodule

// ===== test/csma_ca_mac_controller_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the CSMA/CA MAC controller: clock, reset, event and register
// stimulus, verdict. Uses csma_pkg, csma_ca_mac_controller and csma_ca_mac_checker.
module csma_ca_mac_controller_tb;

  logic                            clk = 0;
  logic                            rst = 1;
  logic                            in_valid = 0;
  logic                            in_ready;
  logic [csma_pkg::KIND_W-1:0]     kind = csma_pkg::K_TICK;
  logic [csma_pkg::MED_W-1:0]      medium_req = csma_pkg::MED_IDLE;
  logic                            fcs_ok = 0, for_us = 0, frame_is_ack = 0;
  logic                            dest_broadcast = 0, dest_multicast = 0;
  logic [csma_pkg::ADDR_W-1:0]     source_address = '0;
  logic [csma_pkg::DRAW_W-1:0]     random_draw = '0;
  logic                            out_valid;
  logic                            out_ready = 0;
  logic [csma_pkg::ACT_W-1:0]      action;
  logic [csma_pkg::MST_W-1:0]      mac_state;
  logic [csma_pkg::ADDR_W-1:0]     ack_destination;
  logic                            want_frame;
  logic                            cfg_valid = 0;
  logic                            cfg_ready;
  logic [csma_pkg::CFG_IDX_W-1:0]  cfg_index = csma_pkg::R_USE_ACK;
  logic [csma_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int                              fail_count, pending;
  logic                            stall_on = 1;
  logic [csma_pkg::MED_W-1:0]      medium_now = csma_pkg::MED_IDLE;

  always #2 clk = ~clk;

  csma_ca_mac_controller u_top (.*);
  csma_ca_mac_checker u_chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side stalls
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (!stall_on) out_ready <= 1;
      else begin
        g = gap_len();
        if (g == 0) out_ready <= 1;
        else begin
          out_ready <= 0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  // valid stays high from one word to the next when there is no gap
  task automatic send_event(input logic [2:0] k, input logic [1:0] med,
                            input logic [5:0] flags, input logic [47:0] src,
                            input logic [31:0] draw);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    kind <= k; medium_req <= med;
    {fcs_ok, for_us, frame_is_ack, dest_broadcast, dest_multicast} <= flags[4:0];
    source_address <= src; random_draw <= draw;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_index <= idx; cfg_data <= val; cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_draw();
    case ($urandom_range(0, 3))
      0: return 32'hFFFF_FFFF;
      1: return $urandom_range(0, 300);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [47:0] rnd_addr();
    return 48'({$urandom, $urandom});
  endfunction

  // one random event, biased toward well-formed exchanges
  task automatic random_event();
    int r;
    logic [2:0] k;
    logic [5:0] fl;
    r = $urandom_range(0, 99);
    if (r < 45) k = csma_pkg::K_TICK;
    else if (r < 57) k = csma_pkg::K_FRAME;
    else if (r < 72) k = csma_pkg::K_MEDIUM;
    else if (r < 85) k = csma_pkg::K_RX_END;
    else if (r < 97) k = csma_pkg::K_TX_DONE;
    else k = 3'($urandom_range(5, 7));
    if (k == csma_pkg::K_MEDIUM) medium_now = 2'($urandom_range(0, 3));
    else if ($urandom_range(0, 9) == 0) medium_now = 2'($urandom_range(0, 3));
    fl = 6'($urandom);
    if ($urandom_range(0, 2) != 0) fl[4] = 1;
    if ($urandom_range(0, 1) == 0) fl[1:0] = 0;
    send_event(k, medium_now, fl, rnd_addr(), rnd_draw());
  endtask

  initial begin
    int n;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: full ACK exchange with small timers
    write_reg(csma_pkg::R_DIFS, 2); write_reg(csma_pkg::R_SIFS, 1);
    write_reg(csma_pkg::R_ACK_TO, 0);
    write_reg(csma_pkg::R_CW_MIN, 1); write_reg(csma_pkg::R_CW_MAX, 3);
    write_reg(csma_pkg::R_CW_MC, 0);
    write_reg(csma_pkg::R_RETRY, 1); write_reg(csma_pkg::R_USE_ACK, 1);
    send_event(csma_pkg::K_FRAME, csma_pkg::MED_IDLE, 6'b000000, '0, 32'hFFFF_FFFF);
    repeat (3) send_event(csma_pkg::K_TICK, csma_pkg::MED_IDLE, 0, '0, 32'hFFFF_FFFF);
    send_event(csma_pkg::K_MEDIUM, 2'd3, 0, '0, 0);
    send_event(csma_pkg::K_MEDIUM, csma_pkg::MED_IDLE, 0, '0, 5);
    repeat (4) send_event(csma_pkg::K_TICK, csma_pkg::MED_IDLE, 0, '0, 7);
    send_event(csma_pkg::K_TX_DONE, csma_pkg::MED_IDLE, 0, '0, 0);
    send_event(csma_pkg::K_TICK, csma_pkg::MED_IDLE, 0, '0, 32'h1234);
    repeat (4) send_event(csma_pkg::K_TICK, csma_pkg::MED_IDLE, 0, '0, 3);
    send_event(csma_pkg::K_TX_DONE, csma_pkg::MED_IDLE, 0, '0, 0);
    send_event(csma_pkg::K_RX_END, csma_pkg::MED_IDLE, 6'b11100, '0, 0);
    send_event(csma_pkg::K_MEDIUM, csma_pkg::MED_RECV, 0, '0, 0);
    send_event(csma_pkg::K_RX_END, csma_pkg::MED_IDLE, 6'b11000, 48'hFFFF_FFFF_FFFF, 0);
    send_event(csma_pkg::K_TICK, csma_pkg::MED_IDLE, 0, '0, 0);
    send_event(csma_pkg::K_MEDIUM, csma_pkg::MED_RECV, 0, '0, 0);
    send_event(csma_pkg::K_RX_END, csma_pkg::MED_IDLE, 6'b00000, '0, 0);
    send_event(csma_pkg::K_FRAME, csma_pkg::MED_IDLE, 6'b00011, '0, 9);
    send_event(3'd7, csma_pkg::MED_IDLE, 0, '0, 0);
    drain();
    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(csma_pkg::R_USE_ACK, 1); write_reg(csma_pkg::R_DIFS, 3);
          write_reg(csma_pkg::R_SIFS, 2); write_reg(csma_pkg::R_ACK_TO, 4);
          write_reg(csma_pkg::R_CW_MIN, 0); write_reg(csma_pkg::R_CW_MAX, 2);
          write_reg(csma_pkg::R_CW_MC, 2); write_reg(csma_pkg::R_RETRY, 2);
        end
        1: begin
          write_reg(csma_pkg::R_USE_ACK, 0); write_reg(csma_pkg::R_CW_MIN, 1);
          write_reg(csma_pkg::R_CW_MAX, 1023); write_reg(csma_pkg::R_RETRY, 0);
        end
        2: begin
          // large values; ticks are not meant to finish these timers
          write_reg(csma_pkg::R_USE_ACK, 1); write_reg(csma_pkg::R_DIFS, 16'hFFFF);
          write_reg(csma_pkg::R_SIFS, 16'hFFFF); write_reg(csma_pkg::R_ACK_TO, 16'hFFFF);
          write_reg(csma_pkg::R_CW_MIN, 1023); write_reg(csma_pkg::R_CW_MC, 1023);
          write_reg(csma_pkg::R_RETRY, 15);
        end
        3: begin
          write_reg(csma_pkg::R_DIFS, 0); write_reg(csma_pkg::R_SIFS, 0);
          write_reg(csma_pkg::R_ACK_TO, 1); write_reg(csma_pkg::R_CW_MIN, 3);
          write_reg(csma_pkg::R_CW_MAX, 4); write_reg(csma_pkg::R_CW_MC, 1);
          write_reg(csma_pkg::R_RETRY, 3);
        end
        4: begin
          write_reg(csma_pkg::R_CW_MIN, 16'hAAAA); write_reg(csma_pkg::R_CW_MAX, 16'h5555);
          write_reg(csma_pkg::R_CW_MC, 16'h5555); write_reg(csma_pkg::R_USE_ACK, 16'hFFFE);
        end
        5: begin
          write_reg(csma_pkg::R_USE_ACK, 1); write_reg(csma_pkg::R_DIFS, 1);
          write_reg(csma_pkg::R_SIFS, 3); write_reg(csma_pkg::R_ACK_TO, 2);
          write_reg(csma_pkg::R_CW_MIN, 0); write_reg(csma_pkg::R_CW_MAX, 0);
          write_reg(csma_pkg::R_CW_MC, 0); write_reg(csma_pkg::R_RETRY, 1);
        end
        default: begin
          write_reg(csma_pkg::R_CW_MIN, 2); write_reg(csma_pkg::R_CW_MAX, 1023);
          write_reg(csma_pkg::R_RETRY, 4);
        end
      endcase
      stall_on = (ph != 3);
      n = (ph == 2) ? 60 : 105;
      repeat (n) random_event();
      drain();
    end
    if (fail_count == 0) $display("csma_ca_mac_controller_tb passed");
    else $display("csma_ca_mac_controller_tb failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("csma_ca_mac_controller_tb failed");
    $finish;
  end

endmodule
